>>> design/irconv_pkg.sv
// ----------------------------------------------------------------------------
// irconv_pkg
// Shared constants and codes of the impulse response convolution block.
// ----------------------------------------------------------------------------
package irconv_pkg;

	localparam int DEF_MAX_TAPS = 4096;

	localparam int SAMPLE_W = 16;
	localparam int TAP_W    = 18;
	localparam int COEF_W   = 25;
	localparam int SIG_W    = 32;
	localparam int LEN_W    = 13;
	localparam int GAIN_W   = 17;
	localparam int EQ_NCOEF = 15;
	localparam int EQ_NDLY  = 12;
	localparam int EQ_ACC_W = 60;

	localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1 << 20);
	localparam logic [GAIN_W-1:0] GAIN_UNITY = GAIN_W'(65536);

	typedef enum logic [1:0] {
		CMD_SAMPLE = 2'd0,
		CMD_TAP    = 2'd1,
		CMD_COEF   = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		REG_ENABLE    = 2'd0,
		REG_IR_LENGTH = 2'd1,
		REG_GAIN      = 2'd2,
		REG_EQ_BYPASS = 2'd3
	} reg_idx_t;

endpackage

>>> design/ir_convolution_with_tone_eq.sv
// ----------------------------------------------------------------------------
// ir_convolution_with_tone_eq
// Direct-form impulse response convolution, three-band biquad EQ and gain.
// ----------------------------------------------------------------------------
// Usage: an input word carries a command. A sample command is convolved with
// the first ir_length taps of the tap memory, passes the optional biquad
// cascade, is scaled by gain_q and leaves as one output word. Tap writes,
// coefficient writes and history clears produce no output word.
// The sample history and the taps sit in two single-port-read memories; the
// convolution issues one tap read per cycle into one 16x18 multiplier. A
// sample runs through the tap loop (tap read, product, accumulate), the
// three EQ bands in turn when the EQ is in use, the gain states G1
// (multiply), G2 (clamp) and G3 (round) and the output state; the next word
// is taken once the output state has handed its word on. Passthrough
// samples (block disabled or length zero) go straight to the output state.
// One item is worked on at a time; in_ready is high whenever the sequencer
// is idle, even while a finished output word still waits for out_ready.
// After reset, after a clear command and when enable goes from 0 to 1, the
// history memory is swept to zero, one entry per cycle over all MAX_TAPS
// entries, and no input word is taken meanwhile. Configuration writes are
// taken always. MAX_TAPS must be a power of two.
// ----------------------------------------------------------------------------
module ir_convolution_with_tone_eq
	import irconv_pkg::*;
#(
	parameter int MAX_TAPS = DEF_MAX_TAPS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [3:0]                 paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 command,
	input  logic signed [SAMPLE_W-1:0] sample_in,
	input  logic [11:0]                tap_index,
	input  logic signed [TAP_W-1:0]    tap_value,
	input  logic [3:0]                 coeff_index,
	input  logic signed [COEF_W-1:0]   coeff_value,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [SAMPLE_W-1:0] sample_out
);

	localparam int AW  = $clog2(MAX_TAPS);
	localparam int CW  = AW + 1;
	localparam int LW  = (CW > LEN_W) ? CW : LEN_W;
	localparam int ACW = SAMPLE_W + TAP_W + AW;
	localparam int PW  = SAMPLE_W + TAP_W;
	localparam int EPW = COEF_W + SIG_W;
	localparam int GPW = SIG_W + GAIN_W + 1;
	localparam int CLW = 42;
	localparam int TW  = CLW + 15;

	typedef enum logic [2:0] {
		ST_IDLE, ST_CLEAR, ST_MAC, ST_EQ, ST_G1, ST_G2, ST_G3, ST_OUT
	} state_t;

	// Configuration registers.
	logic              enable_q;
	logic [LEN_W-1:0]  ir_length_q;
	logic [GAIN_W-1:0] gain_q;
	logic              eq_bypass_q;

	logic     cfg_wr;
	reg_idx_t cfg_idx;
	logic     en_rise;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);
	assign en_rise = cfg_wr && (cfg_idx == REG_ENABLE) && pwdata[0] && !enable_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q    <= 1'b0;
			ir_length_q <= '0;
			gain_q      <= GAIN_UNITY;
			eq_bypass_q <= 1'b1;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_ENABLE:    enable_q    <= pwdata[0];
				REG_IR_LENGTH: ir_length_q <= pwdata[LEN_W-1:0];
				REG_GAIN:      gain_q      <= pwdata[GAIN_W-1:0];
				REG_EQ_BYPASS: eq_bypass_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (reg_idx_t'(paddr[3:2]))
			REG_ENABLE:    prdata = {31'd0, enable_q};
			REG_IR_LENGTH: prdata = {{(32-LEN_W){1'b0}}, ir_length_q};
			REG_GAIN:      prdata = {{(32-GAIN_W){1'b0}}, gain_q};
			REG_EQ_BYPASS: prdata = {31'd0, eq_bypass_q};
			default:       prdata = '0;
		endcase
	end

	// Sequencer state.
	state_t                     state_q;
	logic [AW-1:0]              ptr_q;
	logic [AW-1:0]              clr_addr_q;
	logic [AW-1:0]              rd_pos_q;
	logic [CW-1:0]              k_q;
	logic [CW-1:0]              len_q;
	logic                       iss_s1;
	logic                       prd_v_s2;
	logic signed [PW-1:0]       prod_s2;
	logic signed [ACW-1:0]      acc_q;
	logic signed [SIG_W-1:0]    x_q;
	logic [1:0]                 band_q;
	logic [2:0]                 j_q;
	logic                       ev_s1;
	logic                       esub_s1;
	logic signed [EPW-1:0]      eprod_s1;
	logic signed [EQ_ACC_W-1:0] eacc_q;
	logic signed [GPW-1:0]      gprod_q;
	logic signed [CLW-1:0]      gcl_q;
	logic signed [SAMPLE_W-1:0] res_q;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] out_q;
	logic signed [COEF_W-1:0]   eq_c_q [EQ_NCOEF];
	logic signed [SIG_W-1:0]    eq_d_q [EQ_NDLY];

	// Memories.
	logic signed [TAP_W-1:0]    tap_mem  [MAX_TAPS];
	logic signed [SAMPLE_W-1:0] hist_mem [MAX_TAPS];
	logic signed [TAP_W-1:0]    tap_rd_q;
	logic signed [SAMPLE_W-1:0] hist_rd_q;

	logic accept;
	logic conv_on;
	logic hist_we;
	logic [AW-1:0] hist_waddr;
	logic signed [SAMPLE_W-1:0] hist_wdata;

	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign conv_on    = enable_q && (ir_length_q != '0);
	assign hist_we    = (state_q == ST_CLEAR) ||
	                    (accept && (cmd_t'(command) == CMD_SAMPLE) && conv_on);
	assign hist_waddr = (state_q == ST_CLEAR) ? clr_addr_q : ptr_q;
	assign hist_wdata = (state_q == ST_CLEAR) ? '0 : sample_in;

	always_ff @(posedge clk) begin
		if (accept && (cmd_t'(command) == CMD_TAP))
			tap_mem[AW'(tap_index)] <= tap_value;
		tap_rd_q <= tap_mem[k_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (hist_we)
			hist_mem[hist_waddr] <= hist_wdata;
		hist_rd_q <= hist_mem[rd_pos_q];
	end

	// Effective length, bounded by the memory depth.
	logic [LW-1:0] len_x;
	logic [CW-1:0] len_eff;
	assign len_x   = LW'(ir_length_q);
	assign len_eff = (len_x >= LW'(MAX_TAPS)) ? CW'(MAX_TAPS) : CW'(len_x);

	// Convolution sum to Q8.24 with floor and saturation.
	logic signed [ACW-1:0]  acc_sh;
	logic signed [SIG_W-1:0] conv_sig;
	assign acc_sh = acc_q >>> 8;
	always_comb begin
		if ((&acc_sh[ACW-1:SIG_W-1]) || !(|acc_sh[ACW-1:SIG_W-1]))
			conv_sig = acc_sh[SIG_W-1:0];
		else
			conv_sig = acc_sh[ACW-1] ? {1'b1, {(SIG_W-1){1'b0}}} : {1'b0, {(SIG_W-1){1'b1}}};
	end

	// Biquad operand selection and output saturation.
	logic [3:0]                 c_idx;
	logic [3:0]                 d_idx;
	logic [2:0]                 jm1;
	logic signed [SIG_W-1:0]    e_opnd;
	logic signed [EQ_ACC_W-1:0] eacc_sh;
	logic signed [SIG_W-1:0]    eq_y;
	assign c_idx   = 4'({2'd0, band_q} * 4'd5) + 4'(j_q);
	assign jm1     = j_q - 3'd1;
	assign d_idx   = {band_q, jm1[1:0]};
	assign e_opnd  = (j_q == 3'd0) ? x_q : eq_d_q[d_idx];
	assign eacc_sh = eacc_q >>> 20;
	always_comb begin
		if ((&eacc_sh[EQ_ACC_W-1:SIG_W-1]) || !(|eacc_sh[EQ_ACC_W-1:SIG_W-1]))
			eq_y = eacc_sh[SIG_W-1:0];
		else
			eq_y = eacc_sh[EQ_ACC_W-1] ? {1'b1, {(SIG_W-1){1'b0}}} :
			                             {1'b0, {(SIG_W-1){1'b1}}};
	end

	// Gain: clamp to +-2^40, times 32767, divide by 2^40 toward zero.
	localparam logic signed [GPW-1:0] GLIM_P = GPW'(64'sd1 <<< 40);
	localparam logic signed [GPW-1:0] GLIM_N = -GLIM_P;
	logic signed [TW-1:0] g_t;
	logic signed [TW-1:0] g_r;
	assign g_t = (TW'(gcl_q) <<< 15) - TW'(gcl_q);
	assign g_r = g_t[TW-1] ? (g_t + TW'((64'sd1 <<< 40) - 64'sd1)) : g_t;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			ptr_q       <= '0;
			clr_addr_q  <= '0;
			rd_pos_q    <= '0;
			k_q         <= '0;
			len_q       <= '0;
			iss_s1      <= 1'b0;
			prd_v_s2    <= 1'b0;
			band_q      <= '0;
			j_q         <= '0;
			ev_s1       <= 1'b0;
			esub_s1     <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < EQ_NCOEF; i++)
				eq_c_q[i] <= ((i % 5) == 0) ? COEF_ONE : '0;
			for (int i = 0; i < EQ_NDLY; i++)
				eq_d_q[i] <= '0;
		end else begin
			// The output stage reloads the word itself when it is accepted.
			if (out_valid_q && out_ready && (en_rise || (state_q != ST_OUT)))
				out_valid_q <= 1'b0;
			if (en_rise) begin
				// Turning the block on starts from an empty history.
				clr_addr_q <= '0;
				ptr_q      <= '0;
				for (int i = 0; i < EQ_NDLY; i++)
					eq_d_q[i] <= '0;
				state_q <= ST_CLEAR;
			end else begin
				case (state_q)
					ST_IDLE: begin
						if (accept) begin
							case (cmd_t'(command))
								CMD_SAMPLE: begin
									if (conv_on) begin
										rd_pos_q <= ptr_q;
										ptr_q    <= ptr_q + 1'b1;
										k_q      <= '0;
										len_q    <= len_eff;
										acc_q    <= '0;
										iss_s1   <= 1'b0;
										prd_v_s2 <= 1'b0;
										state_q  <= ST_MAC;
									end else begin
										res_q   <= sample_in;
										state_q <= ST_OUT;
									end
								end
								CMD_COEF: begin
									if (coeff_index < 4'(EQ_NCOEF))
										eq_c_q[coeff_index] <= coeff_value;
								end
								CMD_CLEAR: begin
									clr_addr_q <= '0;
									ptr_q      <= '0;
									for (int i = 0; i < EQ_NDLY; i++)
										eq_d_q[i] <= '0;
									state_q <= ST_CLEAR;
								end
								default: ;
							endcase
						end
					end
					ST_CLEAR: begin
						clr_addr_q <= clr_addr_q + 1'b1;
						if (clr_addr_q == AW'(MAX_TAPS - 1))
							state_q <= ST_IDLE;
					end
					ST_MAC: begin
						iss_s1 <= (k_q != len_q);
						if (k_q != len_q) begin
							k_q      <= k_q + 1'b1;
							rd_pos_q <= rd_pos_q - 1'b1;
						end
						prd_v_s2 <= iss_s1;
						if (iss_s1)
							prod_s2 <= tap_rd_q * hist_rd_q;
						if (prd_v_s2)
							acc_q <= acc_q + ACW'(prod_s2);
						if ((k_q == len_q) && !iss_s1 && !prd_v_s2) begin
							x_q     <= conv_sig;
							band_q  <= '0;
							j_q     <= '0;
							ev_s1   <= 1'b0;
							eacc_q  <= '0;
							state_q <= eq_bypass_q ? ST_G1 : ST_EQ;
						end
					end
					ST_EQ: begin
						ev_s1 <= (j_q != 3'd5);
						if (j_q != 3'd5) begin
							eprod_s1 <= eq_c_q[c_idx] * e_opnd;
							esub_s1  <= (j_q >= 3'd3);
							j_q      <= j_q + 3'd1;
						end
						if (ev_s1)
							eacc_q <= esub_s1 ? eacc_q - EQ_ACC_W'(eprod_s1) :
							                    eacc_q + EQ_ACC_W'(eprod_s1);
						if ((j_q == 3'd5) && !ev_s1) begin
							eq_d_q[{band_q, 2'd1}] <= eq_d_q[{band_q, 2'd0}];
							eq_d_q[{band_q, 2'd0}] <= x_q;
							eq_d_q[{band_q, 2'd3}] <= eq_d_q[{band_q, 2'd2}];
							eq_d_q[{band_q, 2'd2}] <= eq_y;
							x_q    <= eq_y;
							eacc_q <= '0;
							j_q    <= '0;
							band_q <= band_q + 2'd1;
							if (band_q == 2'd2)
								state_q <= ST_G1;
						end
					end
					ST_G1: begin
						gprod_q <= x_q * $signed({1'b0, gain_q});
						state_q <= ST_G2;
					end
					ST_G2: begin
						if (gprod_q > GLIM_P)
							gcl_q <= CLW'(GLIM_P);
						else if (gprod_q < GLIM_N)
							gcl_q <= CLW'(GLIM_N);
						else
							gcl_q <= CLW'(gprod_q);
						state_q <= ST_G3;
					end
					ST_G3: begin
						res_q   <= g_r[40 +: SAMPLE_W];
						state_q <= ST_OUT;
					end
					ST_OUT: begin
						if (!out_valid_q || out_ready) begin
							out_valid_q <= 1'b1;
							out_q       <= res_q;
							state_q     <= ST_IDLE;
						end
					end
					default: state_q <= ST_IDLE;
				endcase
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = out_q;

	a_mac_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MAC) |-> (k_q <= len_q))
		else $error("tap counter ran past the length");

	a_clear_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR && clr_addr_q == AW'(MAX_TAPS - 1) && !en_rise)
		|=> (state_q == ST_IDLE && ptr_q == '0))
		else $error("clear sweep did not end with an empty history");

	a_conv_start: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd_t'(command) == CMD_SAMPLE && conv_on && !en_rise)
		|=> (state_q == ST_MAC && ptr_q == $past(ptr_q) + 1'b1))
		else $error("convolved sample did not start the tap loop");

endmodule

>>> verif/ir_convolution_with_tone_eq_test.sv
// ----------------------------------------------------------------------------
// ir_convolution_with_tone_eq_test
// Self-checking testbench: queued command words are driven through the
// valid/ready input, every output word is compared with an in-bench
// prediction of the convolution, EQ and gain path, and the registers are
// moved through several settings over the APB-style port.
// ----------------------------------------------------------------------------
module ir_convolution_with_tone_eq_test;
	import irconv_pkg::*;

	localparam int NTAPS = DEF_MAX_TAPS;
	localparam int STALL_LIMIT = 40000;
	localparam int SETTLE = 4400;
	localparam int USED_TAPS = 32;

	typedef struct {
		cmd_t              op;
		logic signed [15:0] smp;
		logic [11:0]        tidx;
		logic signed [17:0] tval;
		logic [3:0]         cidx;
		logic signed [24:0] cval;
	} word_t;

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 0;
	logic in_ready;
	logic [1:0] command = '0;
	logic signed [15:0] sample_in = '0;
	logic [11:0] tap_index = '0;
	logic signed [17:0] tap_value = '0;
	logic [3:0] coeff_index = '0;
	logic signed [24:0] coeff_value = '0;
	logic out_valid;
	logic out_ready = 0;
	logic signed [15:0] sample_out;

	ir_convolution_with_tone_eq DUT (.*);

	always #6 clk = ~clk;

	// Shadow of the block's state.
	logic signed [17:0] taps [NTAPS];
	logic signed [15:0] hist [NTAPS];
	int unsigned hist_ptr;
	logic signed [24:0] coefs [EQ_NCOEF];
	longint eq_dly [EQ_NDLY];
	bit en_r;
	int unsigned len_r;
	longint gain_r;
	bit bypass_r;

	word_t pending_words[$];
	logic signed [15:0] expected_samples[$];
	int errors = 0;
	bit calm = 0;
	bit pressure_arm = 0;
	bit in_taken = 0;
	int idle_cycles = 0;

	function automatic longint sat32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic void wipe_history();
		foreach (hist[i]) hist[i] = '0;
		hist_ptr = 0;
		foreach (eq_dly[i]) eq_dly[i] = 0;
	endfunction

	function automatic longint tone_eq(longint x);
		longint acc, y;
		for (int b = 0; b < 3; b++) begin
			acc = longint'(coefs[b*5]) * x + longint'(coefs[b*5+1]) * eq_dly[b*4]
				+ longint'(coefs[b*5+2]) * eq_dly[b*4+1]
				- longint'(coefs[b*5+3]) * eq_dly[b*4+2]
				- longint'(coefs[b*5+4]) * eq_dly[b*4+3];
			y = sat32(acc >>> 20);
			eq_dly[b*4+1] = eq_dly[b*4];
			eq_dly[b*4] = x;
			eq_dly[b*4+3] = eq_dly[b*4+2];
			eq_dly[b*4+2] = y;
			x = y;
		end
		return x;
	endfunction

	// Applies one word to the shadow state; returns 1 when it yields an output.
	function automatic bit process_word(word_t w, output logic signed [15:0] res);
		int unsigned n, pos;
		longint acc, sig, scaled;
		longint lim = 64'sd1 << 40;
		res = '0;
		case (w.op)
			CMD_TAP: begin
				taps[w.tidx] = w.tval;
				return 0;
			end
			CMD_COEF: begin
				if (w.cidx < EQ_NCOEF) coefs[w.cidx] = w.cval;
				return 0;
			end
			CMD_CLEAR: begin
				wipe_history();
				return 0;
			end
			default: ;
		endcase
		if (!en_r || len_r == 0) begin
			res = w.smp;
			return 1;
		end
		n = (len_r > NTAPS) ? NTAPS : len_r;
		pos = hist_ptr;
		hist[pos] = w.smp;
		acc = 0;
		for (int k = 0; k < n; k++) begin
			acc += longint'(taps[k]) * longint'(hist[pos]);
			pos = (pos == 0) ? NTAPS - 1 : pos - 1;
		end
		hist_ptr = (hist_ptr + 1) % NTAPS;
		sig = sat32(acc >>> 8);
		if (!bypass_r) sig = tone_eq(sig);
		scaled = sig * gain_r;
		if (scaled > lim) scaled = lim;
		if (scaled < -lim) scaled = -lim;
		scaled = (scaled * 32767) / lim;
		res = scaled[15:0];
		return 1;
	endfunction

	// Acceptance on both channels and checking of output words.
	always @(posedge clk) begin
		logic signed [15:0] r;
		logic signed [15:0] want;
		in_taken <= in_valid && in_ready;
		if (in_valid && in_ready) begin
			if (process_word('{cmd_t'(command), sample_in, tap_index, tap_value,
					coeff_index, coeff_value}, r))
				expected_samples.push_back(r);
		end
		if (out_valid && out_ready) begin
			if (expected_samples.size() == 0) begin
				errors++;
				if (errors <= 10) $display("Unexpected output word %0d", sample_out);
			end else begin
				want = expected_samples.pop_front();
				if (sample_out !== want) begin
					errors++;
					if (errors <= 10)
						$display("sample_out mismatch: expected %0d, got %0d", want, sample_out);
				end
			end
		end
	end

	// Sender: holds a word until it is taken, with random idle bursts.
	always @(negedge clk) begin
		word_t w;
		if (arst_n && (!in_valid || in_taken)) begin
			if (idle_cycles > 0) begin
				idle_cycles <= idle_cycles - 1;
				in_valid <= 0;
			end else if (pending_words.size() > 0) begin
				w = pending_words.pop_front();
				in_valid <= 1;
				command <= w.op;
				sample_in <= w.smp;
				tap_index <= w.tidx;
				tap_value <= w.tval;
				coeff_index <= w.cidx;
				coeff_value <= w.cval;
				if (!calm && $urandom_range(0, 5) == 0) idle_cycles <= $urandom_range(1, 4);
			end else begin
				in_valid <= 0;
			end
		end
	end

	// Receiver: random stall bursts, and one long hold-off when armed.
	int stall_cycles = 0;
	bit pressure_done = 0;
	always @(negedge clk) begin
		if (pressure_arm && !pressure_done) begin
			pressure_done <= 1;
			stall_cycles <= 600;
			out_ready <= 0;
		end else if (stall_cycles > 0) begin
			stall_cycles <= stall_cycles - 1;
			out_ready <= 0;
		end else if (!calm && $urandom_range(0, 4) == 0) begin
			stall_cycles <= $urandom_range(0, 3);
			out_ready <= 0;
		end else begin
			out_ready <= 1;
		end
	end

	// Watchdog on cycles in which nothing is accepted.
	int quiet = 0;
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || psel) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet >= STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic reg_write(reg_idx_t idx, int unsigned v);
		@(negedge clk);
		psel <= 1;
		pwrite <= 1;
		penable <= 0;
		paddr <= 4'(4 * idx);
		pwdata <= v;
		@(negedge clk);
		penable <= 1;
		@(posedge clk);
		case (idx)
			REG_ENABLE: begin
				if (v[0] && !en_r) wipe_history();
				en_r = v[0];
			end
			REG_IR_LENGTH: len_r = v & 32'h1FFF;
			REG_GAIN: gain_r = v & 32'h1FFFF;
			default: bypass_r = v[0];
		endcase
		@(negedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
	endtask

	task automatic drain();
		wait (pending_words.size() == 0 && !in_valid && expected_samples.size() == 0);
		repeat (SETTLE) @(negedge clk);
	endtask

	function automatic word_t mk(cmd_t op, int s, int ti, int tv, int ci, int cv);
		return '{op, 16'(s), 12'(ti), 18'(tv), 4'(ci), 25'(cv)};
	endfunction

	function automatic word_t random_word();
		int pick = $urandom_range(0, 99);
		int s = $urandom_range(0, 3) == 0 ? ($urandom_range(0, 1) ? 32767 : -32768)
			: int'($urandom_range(0, 65535)) - 32768;
		if (pick < 72) return mk(CMD_SAMPLE, s, 0, 0, 0, 0);
		if (pick < 84) return mk(CMD_TAP, 0, $urandom_range(0, 4095),
			int'($urandom_range(0, 262143)) - 131072, 0, 0);
		if (pick < 97) begin
			int ci = $urandom_range(0, 15);
			int cv = (ci % 5 == 0) ? int'($urandom_range(0, 1 << 21)) - (1 << 20)
				: int'($urandom_range(0, 1 << 19)) - (1 << 18);
			return mk(CMD_COEF, 0, 0, 0, ci, cv);
		end
		return mk(CMD_CLEAR, 0, 0, 0, 0, 0);
	endfunction

	initial begin
		foreach (taps[i]) taps[i] = '0;
		foreach (coefs[i]) coefs[i] = (i % 5 == 0) ? COEF_ONE : '0;
		wipe_history();
		en_r = 0;
		len_r = 0;
		gain_r = GAIN_UNITY;
		bypass_r = 1;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		// Passthrough with the block disabled, coefficient writes and a clear.
		pending_words.push_back(mk(CMD_SAMPLE, 32767, 0, 0, 0, 0));
		pending_words.push_back(mk(CMD_SAMPLE, -32768, 0, 0, 0, 0));
		pending_words.push_back(mk(CMD_SAMPLE, 0, 0, 0, 0, 0));
		pending_words.push_back(mk(CMD_SAMPLE, -1, 0, 0, 0, 0));
		pending_words.push_back(mk(CMD_COEF, 0, 0, 0, 15, 16777215));
		pending_words.push_back(mk(CMD_COEF, 0, 0, 0, 1, 16777215));
		pending_words.push_back(mk(CMD_COEF, 0, 0, 0, 14, -16777216));
		pending_words.push_back(mk(CMD_CLEAR, 0, 0, 0, 0, 0));
		pending_words.push_back(mk(CMD_SAMPLE, 12345, 0, 0, 0, 0));
		// Every tap below the longest length in use is written first.
		for (int i = 0; i < USED_TAPS; i++) begin
			int tv = int'($urandom_range(0, 8191)) - 4096;
			if (i == 0) tv = 131071;
			if (i == 1) tv = -131072;
			if (i == USED_TAPS - 1) tv = 131071;
			pending_words.push_back(mk(CMD_TAP, 0, i, tv, 0, 0));
		end
		drain();

		// Above-unity gain hits the clamp.
		reg_write(REG_ENABLE, 1);
		reg_write(REG_IR_LENGTH, USED_TAPS);
		reg_write(REG_GAIN, 131071);
		pending_words.push_back(mk(CMD_SAMPLE, 32767, 0, 0, 0, 0));
		pending_words.push_back(mk(CMD_SAMPLE, -32768, 0, 0, 0, 0));
		drain();
		reg_write(REG_IR_LENGTH, USED_TAPS);
		reg_write(REG_GAIN, 0);
		reg_write(REG_EQ_BYPASS, 0);
		pending_words.push_back(mk(CMD_SAMPLE, -32768, 0, 0, 0, 0));
		pending_words.push_back(mk(CMD_SAMPLE, 100, 0, 0, 0, 0));
		drain();

		// Random phases with short lengths.
		for (int ph = 0; ph < 6; ph++) begin
			reg_write(REG_ENABLE, (ph == 2) ? 0 : 1);
			reg_write(REG_IR_LENGTH, (ph == 4) ? 0 : $urandom_range(1, USED_TAPS));
			reg_write(REG_GAIN, (ph == 1) ? 65536 : $urandom_range(0, 131071));
			reg_write(REG_EQ_BYPASS, ph % 2);
			if (ph == 5) calm = 1;
			for (int i = 0; i < 15; i++) pending_words.push_back(random_word());
			if (ph == 3) pressure_arm = 1;
			drain();
		end

		wait (expected_samples.size() == 0);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
